// ===== hdl/dsfl_pkg.sv =====
package dsfl_pkg;

  // Frame length cap, default for the top-level parameter (range 3..255)
  localparam int unsigned MAX_FRAME_LEN_DEF = 128;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // Result status codes
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_START    = 3'd1,
    ST_PROGRESS = 3'd2,
    ST_DONE     = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_BADHDR   = 3'd5
  } status_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_A_SYNC_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_SYNC_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_SYNC_FIRST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_SYNC_SECOND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A_LENGTH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B_LENGTH      = 3'd5;

  // Current register contents, handed to the framer
  typedef struct packed {
    logic [BYTE_W-1:0] kind_a_sync_first;
    logic [BYTE_W-1:0] kind_a_sync_second;
    logic [BYTE_W-1:0] kind_b_sync_first;
    logic [BYTE_W-1:0] kind_b_sync_second;
    logic [BYTE_W-1:0] kind_a_length;
    logic [BYTE_W-1:0] kind_b_length;
  } cfg_t;

  // One result word
  typedef struct packed {
    status_t           status;
    logic              frame_kind;
    logic [BYTE_W-1:0] byte_position;
    logic [BYTE_W-1:0] echo_byte;
    logic              kind_a_ready;
    logic              kind_b_ready;
  } result_t;

endpackage

// ===== hdl/dsfl_cfg_regs.sv =====
module dsfl_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dsfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dsfl_pkg::BYTE_W-1:0]   cfg_wdata,
  output dsfl_pkg::cfg_t                cfg
);
  import dsfl_pkg::*;

  // Register file, written by index; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kind_a_sync_first  <= 8'd170;
      cfg.kind_a_sync_second <= 8'd68;
      cfg.kind_b_sync_first  <= 8'd85;
      cfg.kind_b_sync_second <= 8'd73;
      cfg.kind_a_length      <= 8'd64;
      cfg.kind_b_length      <= 8'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A_SYNC_FIRST:  cfg.kind_a_sync_first  <= cfg_wdata;
        REG_A_SYNC_SECOND: cfg.kind_a_sync_second <= cfg_wdata;
        REG_B_SYNC_FIRST:  cfg.kind_b_sync_first  <= cfg_wdata;
        REG_B_SYNC_SECOND: cfg.kind_b_sync_second <= cfg_wdata;
        REG_A_LENGTH:      cfg.kind_a_length      <= cfg_wdata;
        REG_B_LENGTH:      cfg.kind_b_length      <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/dsfl_framer.sv =====
module dsfl_framer #(
  parameter int unsigned MAX_FRAME_LEN = dsfl_pkg::MAX_FRAME_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [dsfl_pkg::BYTE_W-1:0] rx_byte,
  input  dsfl_pkg::cfg_t              cfg,
  output dsfl_pkg::result_t           res,
  output logic                        in_frame
);
  import dsfl_pkg::*;

  localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_FRAME_LEN);

  logic [BYTE_W-1:0] byte_count, byte_count_next;
  logic [BYTE_W-1:0] header_first, header_first_next;
  logic [BYTE_W-1:0] header_second, header_second_next;
  logic              in_frame_next;

  logic [BYTE_W-1:0] cnt_inc;
  logic [BYTE_W-1:0] hdr2;
  logic              match_a, match_b, at_cap, is_start;

  // Header check sees the second byte as it is being stored
  assign cnt_inc  = byte_count + 8'd1;
  assign hdr2     = (byte_count == 8'd1) ? rx_byte : header_second;
  assign match_a  = (header_first == cfg.kind_a_sync_first) &&
                    (hdr2 == cfg.kind_a_sync_second);
  assign match_b  = (header_first == cfg.kind_b_sync_first) &&
                    (hdr2 == cfg.kind_b_sync_second);
  assign at_cap   = (byte_count >= MAX_LEN);
  assign is_start = (rx_byte == cfg.kind_a_sync_first) ||
                    (rx_byte == cfg.kind_b_sync_first);

  // Result and next state for the current word
  always_comb begin
    res                = '0;
    res.status         = ST_IDLE;
    res.echo_byte      = rx_byte;
    in_frame_next      = in_frame;
    byte_count_next    = byte_count;
    header_first_next  = header_first;
    header_second_next = hdr2;
    if (!in_frame) begin
      header_second_next = header_second;
      if (is_start) begin
        res.status        = ST_START;
        in_frame_next     = 1'b1;
        header_first_next = rx_byte;
        byte_count_next   = 8'd1;
      end
    end else if (at_cap) begin
      // byte past the cap is dropped
      res.status         = ST_OVERFLOW;
      in_frame_next      = 1'b0;
      byte_count_next    = '0;
      header_second_next = header_second;
    end else begin
      res.byte_position = byte_count;
      byte_count_next   = cnt_inc;
      if (match_a) begin
        if (cnt_inc == cfg.kind_a_length) begin
          res.status       = ST_DONE;
          res.kind_a_ready = 1'b1;
          in_frame_next    = 1'b0;
        end else begin
          res.status = ST_PROGRESS;
        end
      end else if (match_b) begin
        res.frame_kind = 1'b1;
        if (cnt_inc == cfg.kind_b_length) begin
          res.status       = ST_DONE;
          res.kind_b_ready = 1'b1;
          in_frame_next    = 1'b0;
        end else begin
          res.status = ST_PROGRESS;
        end
      end else begin
        res.status      = ST_BADHDR;
        in_frame_next   = 1'b0;
        byte_count_next = '0;
      end
    end
  end

  // Frame control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      byte_count <= '0;
    end else if (step) begin
      in_frame   <= in_frame_next;
      byte_count <= byte_count_next;
    end
  end

  // Header bytes, no reset needed
  always_ff @(posedge clk) begin
    if (step) begin
      header_first  <= header_first_next;
      header_second <= header_second_next;
    end
  end

endmodule

// ===== hdl/dual_sync_fixed_length_framer_unit.sv =====
// Byte-stream framer for two fixed-length packet kinds, each named by a
// two-byte sync header. Every byte accepted on the slave side yields exactly
// one result word on the master side: a status code, the frame kind, the
// byte's position in the frame, the byte itself and a one-word completion
// pulse per kind. A word is taken into an input register, processed by the
// framer and held in an output register, so the unit sustains one byte per
// clock; tvalid rises once the word has moved from the input register to the
// output register. Throughput drops only while the output register is
// stalled by m_tready. Configuration writes take effect at once and belong
// while no word is in flight.
module dual_sync_fixed_length_framer_unit #(
  parameter int unsigned MAX_FRAME_LEN = dsfl_pkg::MAX_FRAME_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // slave side; tdata: rx_byte[7:0]
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,
  // master side; tdata: status[2:0], byte_position[10:3], echo_byte[18:11],
  // kind_a_ready[19], kind_b_ready[20], zero[23:21]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [23:0]                    m_tdata,
  // tuser: frame_kind[0]
  output logic                           m_tuser,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [dsfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dsfl_pkg::BYTE_W-1:0]    cfg_wdata
);
  import dsfl_pkg::*;

  cfg_t              cfg;
  result_t           res;
  result_t           out_res;
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              out_valid;
  logic              advance;
  logic              in_frame;

  // Word moves from input to output register when the latter is free
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  dsfl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dsfl_framer #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_framer (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .rx_byte  (in_byte),
    .cfg      (cfg),
    .res      (res),
    .in_frame (in_frame)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.frame_kind;
  assign m_tdata  = {3'b000, out_res.kind_b_ready, out_res.kind_a_ready,
                     out_res.echo_byte, out_res.byte_position, out_res.status};

  // At most one kind completes per word
  a_one_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_res.kind_a_ready && out_res.kind_b_ready))
    else $error("both completion pulses set");

  // Completion pulse only with done status
  a_ready_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_res.kind_a_ready || out_res.kind_b_ready))
      |-> (out_res.status == ST_DONE))
    else $error("completion pulse without done status");

  // Kind B reported only inside a matched frame
  a_kind_b: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.frame_kind)
      |-> (out_res.status == ST_PROGRESS || out_res.status == ST_DONE))
    else $error("kind B flagged outside a matched frame");

  // A finished, overflowed or rejected frame leaves the framer idle
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (advance && (res.status == ST_DONE || res.status == ST_OVERFLOW ||
                 res.status == ST_BADHDR)) |=> !in_frame)
    else $error("framer still in frame after frame end");

endmodule
